// ----- src/itpl_pkg.sv -----
// ---------------------------------------------------------------------------
// itpl_pkg
// shared constants and types of the isolation tree path length unit
// ---------------------------------------------------------------------------
`default_nettype none
package itpl_pkg;

    localparam int MAX_TREES = 64;
    localparam int MAX_NODES = 256;
    localparam int MAX_ATTRS = 16;

    localparam int TREE_W = $clog2(MAX_TREES);
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ATTR_W = $clog2(MAX_ATTRS);
    localparam int SLOT_W = TREE_W + NODE_W;
    localparam int TCNT_W = TREE_W + 1;

    localparam logic [22:0] TOTAL_MAX = 23'h7FFFFF;

    localparam logic [1:0] CFG_TREE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DEPTH_LIMIT = 2'd1;
    localparam logic [1:0] CFG_RANGE_MODE  = 2'd2;

    localparam logic OP_NODE_WRITE = 1'b0;
    localparam logic OP_SAMPLE     = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_total;
        logic clear_walk;
        logic read_node;
        logic eval_step;
        logic add_tree;
    } itpl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic last_tree;
    } itpl_status_t;

endpackage
`default_nettype wire

// ----- src/itpl_ctrl.sv -----
// ---------------------------------------------------------------------------
// itpl_ctrl
// sequencer for the tree walks of one sample
// ---------------------------------------------------------------------------
`default_nettype none
module itpl_ctrl
    import itpl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         walk_start,
    input  wire logic         no_trees,
    input  wire itpl_status_t status,
    output itpl_cmd_t         cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ADD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (walk_start)
                begin
                    cmd.clear_total = 1'b1;
                    cmd.clear_walk  = 1'b1;
                    state_next      = no_trees ? S_DONE : S_READ;
                end
            end
            S_READ:
            begin
                cmd.read_node = 1'b1;
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.walk_done)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    cmd.eval_step = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_ADD:
            begin
                cmd.add_tree   = 1'b1;
                cmd.clear_walk = 1'b1;
                state_next     = status.last_tree ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && walk_start) |=> busy)
        else $error("walk start did not leave idle");
    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");
    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_EVAL))
        else $error("node read not followed by evaluation");

endmodule
`default_nettype wire

// ----- src/itpl_datapath.sv -----
// ---------------------------------------------------------------------------
// itpl_datapath
// node memory, sample row, walk registers and depth accumulator
// ---------------------------------------------------------------------------
`default_nettype none
module itpl_datapath
    import itpl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               node_we,
    input  wire logic               sample_we,
    input  wire logic [5:0]         tree_index,
    input  wire logic [7:0]         node_index,
    input  wire logic               node_splits,
    input  wire logic [3:0]         attribute,
    input  wire logic signed [31:0] value,
    input  wire logic signed [31:0] lower_limit,
    input  wire logic signed [31:0] upper_limit,
    input  wire logic [7:0]         left_child,
    input  wire logic [7:0]         right_child,
    input  wire logic [15:0]        leaf_adjust,
    input  wire logic [TCNT_W-1:0]  trees,
    input  wire logic [7:0]         depth_limit,
    input  wire logic               range_mode,
    input  wire itpl_cmd_t          cmd,
    output itpl_status_t            status,
    output logic [22:0]             total
);

    typedef struct packed {
        logic               interior;
        logic [3:0]         attr;
        logic signed [31:0] split;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [7:0]         left;
        logic [7:0]         right;
        logic [15:0]        adjust;
    } node_t;

    node_t node_mem [MAX_TREES*MAX_NODES];
    node_t node_rd_reg;
    logic signed [31:0] sample_mem [MAX_ATTRS];

    logic [TREE_W-1:0] tree_reg;
    logic [NODE_W-1:0] node_reg;
    logic [7:0]        steps_reg;
    logic [7:0]        counted_reg;
    logic [22:0]       total_reg;

    logic [SLOT_W-1:0]  wr_slot;
    logic signed [31:0] sv;
    logic               in_range;
    logic [NODE_W-1:0]  next_node;
    logic [23:0]        sum;

    assign wr_slot = {tree_index[TREE_W-1:0], node_index[NODE_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[wr_slot] <= '{node_splits, attribute, value, lower_limit,
                                   upper_limit, left_child, right_child, leaf_adjust};
        end
        if (cmd.read_node)
        begin
            node_rd_reg <= node_mem[{tree_reg, node_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[attribute[ATTR_W-1:0]] <= value;
        end
    end

    assign sv        = sample_mem[node_rd_reg.attr[ATTR_W-1:0]];
    assign in_range  = (sv >= node_rd_reg.lo) && (sv <= node_rd_reg.hi);
    assign next_node = (sv < node_rd_reg.split) ? node_rd_reg.left[NODE_W-1:0]
                                                : node_rd_reg.right[NODE_W-1:0];
    assign sum = {1'b0, total_reg} + {8'd0, counted_reg, 8'd0}
                 + {8'd0, node_rd_reg.adjust};

    assign status.walk_done = !node_rd_reg.interior || (steps_reg >= depth_limit);
    assign status.last_tree = ({1'b0, tree_reg} == TCNT_W'(trees - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_reg    <= '0;
            node_reg    <= '0;
            steps_reg   <= '0;
            counted_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            if (cmd.clear_total)
            begin
                total_reg <= '0;
                tree_reg  <= '0;
            end
            if (cmd.clear_walk)
            begin
                node_reg    <= '0;
                steps_reg   <= '0;
                counted_reg <= '0;
            end
            if (cmd.eval_step)
            begin
                node_reg  <= next_node;
                steps_reg <= steps_reg + 8'd1;
                if (!range_mode || in_range)
                begin
                    counted_reg <= counted_reg + 8'd1;
                end
            end
            if (cmd.add_tree)
            begin
                total_reg <= sum[23] ? TOTAL_MAX : sum[22:0];
                tree_reg  <= tree_reg + 1'b1;
            end
        end
    end

    assign total = total_reg;

    a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval_step |-> (steps_reg < depth_limit))
        else $error("step taken beyond depth limit");
    a_counted_le_steps: assert property (@(posedge clk) disable iff (!rst_n)
        counted_reg <= steps_reg)
        else $error("counted steps exceed steps taken");
    a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_tree |=> (total_reg >= $past(total_reg)))
        else $error("depth total decreased");

endmodule
`default_nettype wire

// ----- src/isolation_tree_path_length_unit.sv -----
// ---------------------------------------------------------------------------
// isolation_tree_path_length_unit
// forest walker that sums isolation tree path lengths of one sample
// ---------------------------------------------------------------------------
// an item is taken when start is high and busy is low. op 0 writes one tree
// node into the node memory, op 1 stores one sample attribute value. node
// writes and sample items without last_attribute leave busy low and give
// no result. a sample item with last_attribute walks trees 0 to
// tree_count-1, tree_count capped at 64, from node 0 and pulses done
// with total_depth for one cycle. each visited node takes a registered
// node memory read, then a compare and step, and each tree ends with a
// state that adds its depth to the sum. busy stays high from the
// accepting edge until done has been shown, so no item is taken during a
// walk. tree_count 0 gives done with total_depth 0 and no walk.
// reset sets tree_count 64, depth_limit 255, range_mode 0; node memory and
// sample row are undefined until written. config writes (cfg_we, cfg_index,
// cfg_data) are taken at any edge but belong to idle times. the receiver
// cannot stall: done is a single-cycle strobe.
// ---------------------------------------------------------------------------
`default_nettype none
module isolation_tree_path_length_unit
    import itpl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               op,
    input  wire logic [5:0]         tree_index,
    input  wire logic [7:0]         node_index,
    input  wire logic               node_splits,
    input  wire logic [3:0]         attribute,
    input  wire logic signed [31:0] value,
    input  wire logic signed [31:0] lower_limit,
    input  wire logic signed [31:0] upper_limit,
    input  wire logic [7:0]         left_child,
    input  wire logic [7:0]         right_child,
    input  wire logic [15:0]        leaf_adjust,
    input  wire logic               last_attribute,
    output logic                    done,
    output logic [22:0]             total_depth,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);

    logic [6:0]       tree_count_reg;
    logic [7:0]       depth_limit_reg;
    logic             range_mode_reg;
    logic             accept;
    logic             walk_start;
    logic [TCNT_W-1:0] trees;
    itpl_cmd_t        cmd;
    itpl_status_t     status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count_reg  <= 7'd64;
            depth_limit_reg <= 8'd255;
            range_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TREE_COUNT:  tree_count_reg  <= cfg_data[6:0];
                CFG_DEPTH_LIMIT: depth_limit_reg <= cfg_data;
                CFG_RANGE_MODE:  range_mode_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    assign accept     = start && !busy;
    assign walk_start = accept && (op == OP_SAMPLE) && last_attribute;
    assign trees      = ({1'b0, tree_count_reg} > MAX_TREES) ? TCNT_W'(MAX_TREES)
                                                              : TCNT_W'(tree_count_reg);

    itpl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .walk_start (walk_start),
        .no_trees   (trees == '0),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    itpl_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .node_we       (accept && (op == OP_NODE_WRITE)),
        .sample_we     (accept && (op == OP_SAMPLE)),
        .tree_index    (tree_index),
        .node_index    (node_index),
        .node_splits   (node_splits),
        .attribute     (attribute),
        .value         (value),
        .lower_limit   (lower_limit),
        .upper_limit   (upper_limit),
        .left_child    (left_child),
        .right_child   (right_child),
        .leaf_adjust   (leaf_adjust),
        .trees         (trees),
        .depth_limit   (depth_limit_reg),
        .range_mode    (range_mode_reg),
        .cmd           (cmd),
        .status        (status),
        .total         (total_depth)
    );

endmodule
`default_nettype wire
